// ===== src/joystick_port_with_autofire_macros.svh =====
// ----------------------------------------------------------------------------
// Joystick port assertion macros
// Shared concurrent assertion shorthands for the joystick port modules
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_PORT_WITH_AUTOFIRE_MACROS_SVH
`define JOYSTICK_PORT_WITH_AUTOFIRE_MACROS_SVH

// same-cycle implication, checked out of reset
`define JPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jpa assertion failed");

// next-cycle implication, checked out of reset
`define JPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jpa assertion failed");

`endif

// ===== src/jpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick port package
// Codes, widths, reset values and shared types of the joystick port
// ----------------------------------------------------------------------------
package jpa_pkg;

    // default sizes
    localparam int FRAME_WIDTH_DEF      = 32;
    localparam int SHOT_COUNT_WIDTH_DEF = 8;

    // fixed field widths
    localparam int CMD_W       = 4;
    localparam int FRAME_IN_W  = 32;
    localparam int PORT_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int BULLETS_W   = 9;
    localparam int DELAY_W     = 17;

    // register reset values
    localparam logic signed [BULLETS_W-1:0] BULLETS_RESET = -9'sd3;
    localparam logic signed [DELAY_W-1:0]   DELAY_RESET   = 17'sd125;
    localparam logic [PORT_W-1:0]           PORT_IDLE     = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_UP           = 4'd0,
        CMD_DOWN         = 4'd1,
        CMD_LEFT         = 4'd2,
        CMD_RIGHT        = 4'd3,
        CMD_RELEASE_X    = 4'd4,
        CMD_RELEASE_Y    = 4'd5,
        CMD_RELEASE_BOTH = 4'd6,
        CMD_FIRE_PRESS   = 4'd7,
        CMD_FIRE_RELEASE = 4'd8,
        CMD_TICK         = 4'd9
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTOFIRE = 2'd0,
        REG_BULLETS  = 2'd1,
        REG_DELAY    = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_CENTER = 2'd0,
        AXIS_NEG    = 2'd1,
        AXIS_POS    = 2'd2
    } t_axis;

    // configuration write as seen by the fire controller
    typedef struct packed {
        logic                  we;
        t_reg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // accepted item command as seen by the fire controller
    typedef struct packed {
        logic valid;
        t_cmd command;
    } t_step;

    // active-low port byte
    function automatic logic [PORT_W-1:0] port_byte(input t_axis vert, input t_axis horiz,
                                                    input logic fire);
        logic [PORT_W-1:0] r;
        r = PORT_IDLE;
        if (vert == AXIS_NEG)  r[0] = 1'b0;
        if (vert == AXIS_POS)  r[1] = 1'b0;
        if (horiz == AXIS_NEG) r[2] = 1'b0;
        if (horiz == AXIS_POS) r[3] = 1'b0;
        if (fire)              r[4] = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/jpa_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Joystick command channel
// Valid/ready channel carrying one command item and the current frame number
// ----------------------------------------------------------------------------
interface jpa_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [jpa_pkg::CMD_W-1:0]       command;
    logic [jpa_pkg::FRAME_IN_W-1:0]  frame_number;

    modport source (output valid, output command, output frame_number, input ready);
    modport sink   (input valid, input command, input frame_number, output ready);
endinterface

// ===== src/jpa_port_if.sv =====
// ----------------------------------------------------------------------------
// Joystick port byte channel
// Valid/ready channel carrying one active-low port byte per item
// ----------------------------------------------------------------------------
interface jpa_port_if;
    logic                        valid;
    logic                        ready;
    logic [jpa_pkg::PORT_W-1:0]  port_value;

    modport source (output valid, output port_value, input ready);
    modport sink   (input valid, input port_value, output ready);
endinterface

// ===== src/jpa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Joystick configuration channel
// Valid/ready write channel carrying a register index and write data
// ----------------------------------------------------------------------------
interface jpa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [jpa_pkg::CFG_IDX_W-1:0]   index;
    logic [jpa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/jpa_fire_ctrl.sv =====
// ----------------------------------------------------------------------------
// Joystick fire controller
// Fire button, autofire magazine, shot schedule and configuration registers
// ----------------------------------------------------------------------------
`include "joystick_port_with_autofire_macros.svh"

module jpa_fire_ctrl #(
    parameter int FRAME_WIDTH      = jpa_pkg::FRAME_WIDTH_DEF,
    parameter int SHOT_COUNT_WIDTH = jpa_pkg::SHOT_COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  jpa_pkg::t_cfg_wr       i_cfg,
    input  jpa_pkg::t_step         i_step,
    input  logic [FRAME_WIDTH-1:0] i_frame,
    output logic                   o_fire_next
);

    localparam int SAT_W = (SHOT_COUNT_WIDTH > 8) ? SHOT_COUNT_WIDTH : 8;

    // clamp a non-negative burst size to the shot counter range
    function automatic logic [SHOT_COUNT_WIDTH-1:0] sat_count(input logic [7:0] v);
        logic [SAT_W-1:0] v_ext;
        logic [SAT_W-1:0] max_ext;
        v_ext   = SAT_W'(v);
        max_ext = SAT_W'({SHOT_COUNT_WIDTH{1'b1}});
        if (v_ext > max_ext) begin
            sat_count = '1;
        end else begin
            sat_count = SHOT_COUNT_WIDTH'(v_ext);
        end
    endfunction

    logic                                  r_enable, n_enable;
    logic signed [jpa_pkg::BULLETS_W-1:0]  r_bullets, n_bullets;
    logic signed [jpa_pkg::DELAY_W-1:0]    r_delay, n_delay;
    logic                                  r_fire, n_fire;
    logic [SHOT_COUNT_WIDTH-1:0]           r_shots, n_shots;
    logic                                  r_unlim, n_unlim;
    logic [FRAME_WIDTH-1:0]                r_next_shot, n_next_shot;

    logic                   w_loaded;
    logic [FRAME_WIDTH-1:0] w_sched;
    logic [FRAME_WIDTH-1:0] w_delay_ext;
    logic                   w_tick_due;

    assign w_loaded    = r_unlim || (r_shots != '0);
    assign w_delay_ext = FRAME_WIDTH'(r_delay);
    assign w_sched     = i_frame + w_delay_ext;
    assign w_tick_due  = r_enable && !r_delay[jpa_pkg::DELAY_W-1]
                         && (i_frame == r_next_shot) && w_loaded;

    // next state from a config write or an accepted item
    always_comb begin
        n_enable    = r_enable;
        n_bullets   = r_bullets;
        n_delay     = r_delay;
        n_fire      = r_fire;
        n_shots     = r_shots;
        n_unlim     = r_unlim;
        n_next_shot = r_next_shot;
        if (i_cfg.we) begin
            case (i_cfg.index)
                jpa_pkg::REG_AUTOFIRE: begin
                    n_enable = i_cfg.data[0];
                    // only turning autofire off releases the button
                    if (!i_cfg.data[0] && r_enable) n_fire = 1'b0;
                end
                jpa_pkg::REG_BULLETS: begin
                    n_bullets = i_cfg.data[jpa_pkg::BULLETS_W-1:0];
                    // a new burst size reloads a loaded magazine
                    if (n_bullets != r_bullets && w_loaded) begin
                        n_unlim = n_bullets[jpa_pkg::BULLETS_W-1];
                        n_shots = n_bullets[jpa_pkg::BULLETS_W-1]
                                  ? '0 : sat_count(n_bullets[7:0]);
                    end
                end
                jpa_pkg::REG_DELAY: begin
                    n_delay = i_cfg.data[jpa_pkg::DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_step.valid) begin
            case (i_step.command)
                jpa_pkg::CMD_FIRE_PRESS: begin
                    if (!r_enable) begin
                        n_fire = 1'b1;
                    end else if (w_loaded) begin
                        // cease fire
                        n_shots = '0;
                        n_unlim = 1'b0;
                        n_fire  = 1'b0;
                    end else begin
                        // load magazine and schedule the first toggle
                        n_fire      = 1'b1;
                        n_unlim     = r_bullets[jpa_pkg::BULLETS_W-1];
                        n_shots     = r_bullets[jpa_pkg::BULLETS_W-1]
                                      ? '0 : sat_count(r_bullets[7:0]);
                        n_next_shot = w_sched;
                    end
                end
                jpa_pkg::CMD_FIRE_RELEASE: begin
                    if (!r_enable) n_fire = 1'b0;
                end
                jpa_pkg::CMD_TICK: begin
                    if (w_tick_due) begin
                        n_fire = !r_fire;
                        if (r_fire && !r_unlim) n_shots = r_shots - 1'b1;
                        n_next_shot = w_sched;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_bullets   <= jpa_pkg::BULLETS_RESET;
            r_delay     <= jpa_pkg::DELAY_RESET;
            r_fire      <= 1'b0;
            r_shots     <= '0;
            r_unlim     <= 1'b0;
            r_next_shot <= '0;
        end else begin
            r_enable    <= n_enable;
            r_bullets   <= n_bullets;
            r_delay     <= n_delay;
            r_fire      <= n_fire;
            r_shots     <= n_shots;
            r_unlim     <= n_unlim;
            r_next_shot <= n_next_shot;
        end
    end

    assign o_fire_next = n_fire;

    // checks
    `JPA_ASSERT_NOW(a_unlim_no_count, i_clk, i_rst_n, r_unlim, r_shots == '0)
    `JPA_ASSERT_NEXT(a_tick_idle_when_off, i_clk, i_rst_n,
        i_step.valid && !i_cfg.we && i_step.command == jpa_pkg::CMD_TICK && !r_enable,
        $stable(r_fire))
    `JPA_ASSERT_NEXT(a_disable_clears_fire, i_clk, i_rst_n,
        i_cfg.we && i_cfg.index == jpa_pkg::REG_AUTOFIRE && !i_cfg.data[0] && r_enable,
        !r_fire)

endmodule

// ===== src/joystick_port_with_autofire.sv =====
// ----------------------------------------------------------------------------
// Joystick port with autofire
// Axis and fire state of a digital joystick, answered as an active-low byte
// ----------------------------------------------------------------------------
// Usage
//   i_cmd   : command items (axis moves, fire press/release, frame tick), each
//             with the current frame number
//   o_res   : one active-low port byte per command item, in order
//   i_cfg   : register writes (0 autofire enable, 1 bullets per burst,
//             2 shot delay in frames); always ready, apply while idle
// The byte of an item is registered into the output register at the edge that
// accepts the item. Throughput is one item per cycle while o_res is ready; the
// state update and the byte are produced by a single compare-and-add stage
// between the state registers and the output register.
// When o_res is stalled the output register holds its byte and i_cmd.ready
// drops until the byte is taken; with o_res ready, items stream at full rate.
// Reset (i_rst_n low, synchronous) centers both axes, releases fire, empties
// the magazine, clears the schedule and loads the register reset values
// (autofire off, bullets -3, delay 125).
// ----------------------------------------------------------------------------
`include "joystick_port_with_autofire_macros.svh"

module joystick_port_with_autofire #(
    parameter int FRAME_WIDTH      = jpa_pkg::FRAME_WIDTH_DEF,
    parameter int SHOT_COUNT_WIDTH = jpa_pkg::SHOT_COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jpa_cmd_if.sink     i_cmd,
    jpa_cfg_if.sink     i_cfg,
    jpa_port_if.source  o_res
);

    logic                         w_in_acc;
    jpa_pkg::t_cmd                w_cmd;
    jpa_pkg::t_cfg_wr             w_cfg;
    jpa_pkg::t_step               w_step;
    logic [FRAME_WIDTH-1:0]       w_frame;
    logic                         w_fire_next;

    jpa_pkg::t_axis               r_vert, n_vert;
    jpa_pkg::t_axis               r_horiz, n_horiz;
    logic                         r_out_valid, n_out_valid;
    logic [jpa_pkg::PORT_W-1:0]   r_port, n_port;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;

    assign w_cmd   = jpa_pkg::t_cmd'(i_cmd.command);
    assign w_frame = FRAME_WIDTH'(i_cmd.frame_number);

    assign w_cfg.we    = i_cfg.valid;
    assign w_cfg.index = jpa_pkg::t_reg_idx'(i_cfg.index);
    assign w_cfg.data  = i_cfg.data;

    assign w_step.valid   = w_in_acc;
    assign w_step.command = w_cmd;

    jpa_fire_ctrl #(
        .FRAME_WIDTH      (FRAME_WIDTH),
        .SHOT_COUNT_WIDTH (SHOT_COUNT_WIDTH)
    ) u_fire (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_step),
        .i_frame     (w_frame),
        .o_fire_next (w_fire_next)
    );

    // axis updates
    always_comb begin
        n_vert  = r_vert;
        n_horiz = r_horiz;
        if (w_in_acc) begin
            case (w_cmd)
                jpa_pkg::CMD_UP:           n_vert  = jpa_pkg::AXIS_NEG;
                jpa_pkg::CMD_DOWN:         n_vert  = jpa_pkg::AXIS_POS;
                jpa_pkg::CMD_LEFT:         n_horiz = jpa_pkg::AXIS_NEG;
                jpa_pkg::CMD_RIGHT:        n_horiz = jpa_pkg::AXIS_POS;
                jpa_pkg::CMD_RELEASE_X:    n_horiz = jpa_pkg::AXIS_CENTER;
                jpa_pkg::CMD_RELEASE_Y:    n_vert  = jpa_pkg::AXIS_CENTER;
                jpa_pkg::CMD_RELEASE_BOTH: begin
                    n_horiz = jpa_pkg::AXIS_CENTER;
                    n_vert  = jpa_pkg::AXIS_CENTER;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_port      = r_port;
        if (w_in_acc) begin
            n_out_valid = 1'b1;
            n_port      = jpa_pkg::port_byte(n_vert, n_horiz, w_fire_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert      <= jpa_pkg::AXIS_CENTER;
            r_horiz     <= jpa_pkg::AXIS_CENTER;
            r_out_valid <= 1'b0;
        end else begin
            r_vert      <= n_vert;
            r_horiz     <= n_horiz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_port <= n_port;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.port_value = r_port;

    // checks
    `JPA_ASSERT_NOW(a_no_accept_when_stalled, i_clk, i_rst_n,
        r_out_valid && !o_res.ready, !i_cmd.ready)
    `JPA_ASSERT_NEXT(a_accept_gives_byte, i_clk, i_rst_n, w_in_acc, r_out_valid)
    `JPA_ASSERT_NOW(a_axis_exclusive, i_clk, i_rst_n, r_out_valid,
        r_port[1:0] != 2'b00 && r_port[3:2] != 2'b00 && r_port[7:5] == 3'b111)

endmodule

// ===== dv/jpa_checker.sv =====
// ----------------------------------------------------------------------------
// Joystick port checker
// Watches the command, register and port byte channels of the joystick port,
// keeps its own model of the stick, the magazine and the shot schedule, and
// checks every port byte against the oldest expected byte
// ----------------------------------------------------------------------------
module jpa_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    jpa_cmd_if   i_cmd,
    jpa_cfg_if   i_cfg,
    jpa_port_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import jpa_pkg::*;

    localparam int SHOT_W   = SHOT_COUNT_WIDTH_DEF;
    localparam int SHOT_MAX = (1 << SHOT_W) - 1;

    // register copies
    logic                        autofire_on;
    logic signed [BULLETS_W-1:0] burst_size;
    logic signed [DELAY_W-1:0]   shot_gap;

    // stick, magazine and schedule
    logic                  fire_down;
    t_axis                 horiz;
    t_axis                 vert;
    logic [SHOT_W-1:0]     shots_left;
    logic                  endless;
    logic [FRAME_IN_W-1:0] next_toggle;

    // port bytes still owed by the block
    logic [PORT_W-1:0] port_bytes_due[$];
    int                fail_count = 0;
    int                pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: port check: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic magazine_loaded();
        return endless || (shots_left != '0);
    endfunction

    function automatic void load_magazine();
        if (burst_size < 0) begin
            endless    = 1'b1;
            shots_left = '0;
        end else begin
            endless    = 1'b0;
            shots_left = (burst_size > SHOT_MAX) ? SHOT_W'(SHOT_MAX) : SHOT_W'(burst_size);
        end
    endfunction

    // next toggle frame, delay sign extended, wrapping
    function automatic void schedule_from(input logic [FRAME_IN_W-1:0] frame);
        next_toggle = frame + {{(FRAME_IN_W-DELAY_W){shot_gap[DELAY_W-1]}}, shot_gap};
    endfunction

    // active-low byte from the current stick state
    function automatic logic [PORT_W-1:0] port_image();
        logic [PORT_W-1:0] b;
        b    = '1;
        b[0] = (vert != AXIS_NEG);
        b[1] = (vert != AXIS_POS);
        b[2] = (horiz != AXIS_NEG);
        b[3] = (horiz != AXIS_POS);
        b[4] = !fire_down;
        return b;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_AUTOFIRE: begin
                if (data[0] != autofire_on) begin
                    autofire_on = data[0];
                    if (!data[0]) fire_down = 1'b0;
                end
            end
            REG_BULLETS: begin
                // a new count reloads a loaded magazine
                if (data[BULLETS_W-1:0] != burst_size) begin
                    burst_size = data[BULLETS_W-1:0];
                    if (magazine_loaded()) load_magazine();
                end
            end
            REG_DELAY: shot_gap = data[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void apply_item(input logic [CMD_W-1:0] code,
                                       input logic [FRAME_IN_W-1:0] frame);
        case (code)
            CMD_UP:           vert  = AXIS_NEG;
            CMD_DOWN:         vert  = AXIS_POS;
            CMD_LEFT:         horiz = AXIS_NEG;
            CMD_RIGHT:        horiz = AXIS_POS;
            CMD_RELEASE_X:    horiz = AXIS_CENTER;
            CMD_RELEASE_Y:    vert  = AXIS_CENTER;
            CMD_RELEASE_BOTH: begin
                horiz = AXIS_CENTER;
                vert  = AXIS_CENTER;
            end
            CMD_FIRE_PRESS: begin
                // with autofire a press either ceases fire or starts a burst
                if (!autofire_on) begin
                    fire_down = 1'b1;
                end else if (magazine_loaded()) begin
                    shots_left = '0;
                    endless    = 1'b0;
                    fire_down  = 1'b0;
                end else begin
                    fire_down = 1'b1;
                    load_magazine();
                    schedule_from(frame);
                end
            end
            CMD_FIRE_RELEASE: begin
                if (!autofire_on) fire_down = 1'b0;
            end
            CMD_TICK: begin
                // due tick toggles the button, a release spends a shot
                if (autofire_on && !shot_gap[DELAY_W-1] && frame == next_toggle &&
                    magazine_loaded()) begin
                    if (fire_down) begin
                        fire_down = 1'b0;
                        if (!endless) shots_left = shots_left - 1'b1;
                    end else begin
                        fire_down = 1'b1;
                    end
                    schedule_from(frame);
                end
            end
            default: ;
        endcase
    endfunction

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        logic [PORT_W-1:0] want;
        if (!i_rst_n) begin
            autofire_on = 1'b0;
            burst_size  = BULLETS_RESET;
            shot_gap    = DELAY_RESET;
            fire_down   = 1'b0;
            horiz       = AXIS_CENTER;
            vert        = AXIS_CENTER;
            shots_left  = '0;
            endless     = 1'b0;
            next_toggle = '0;
            port_bytes_due.delete();
        end else begin
            // result first, so a byte never matches an item of the same edge
            if (i_res.valid && i_res.ready) begin
                if (port_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected port byte %02h", i_res.port_value));
                end else begin
                    want = port_bytes_due.pop_front();
                    if (i_res.port_value !== want)
                        report_mismatch($sformatf("port byte %02h, expected %02h",
                                                  i_res.port_value, want));
                end
            end
            if (i_cfg.valid && i_cfg.ready) apply_reg_write(i_cfg.index, i_cfg.data);
            if (i_cmd.valid && i_cmd.ready) begin
                apply_item(i_cmd.command, i_cmd.frame_number);
                port_bytes_due.push_back(port_image());
            end
        end
        pending = port_bytes_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Joystick port testbench
// Drives directed and random command items and register writes into the
// joystick port with random idle cycles on both sides; the checker beside
// the block predicts and compares every port byte
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jpa_pkg::*;

    localparam int ITEM_TARGET = 900;
    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_PCT    = 32;
    localparam int STEADY_LO   = 350;
    localparam int STEADY_HI   = 500;

    // codes the package leaves unnamed
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
    localparam logic [CMD_W-1:0]     CMD_UNDEF_LO = 4'd10;
    localparam logic [CMD_W-1:0]     CMD_UNDEF_HI = 4'd15;

    logic i_clk;
    logic i_rst_n;

    jpa_cmd_if  cmd_ch ();
    jpa_cfg_if  cfg_ch ();
    jpa_port_if res_ch ();

    int                    fail_count;
    int                    pending;
    int                    items_sent   = 0;
    int                    stall_cycles = 0;
    logic                  steady;
    logic [FRAME_IN_W-1:0] frame_now;

    joystick_port_with_autofire dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    jpa_checker port_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // a stretch of items with no idling on either side
    assign steady = (items_sent >= STEADY_LO) && (items_sent < STEADY_HI);

    // port byte receiver stalls at random
    always @(negedge i_clk) begin
        res_ch.ready <= i_rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one command item, with random idle cycles ahead of it
    task automatic send_item(input logic [CMD_W-1:0] code, input logic [FRAME_IN_W-1:0] frame);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= code;
        cmd_ch.frame_number <= frame;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // hold off until every port byte has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // all three registers, unused upper data bits random
    task automatic program_regs(input logic af, input logic signed [BULLETS_W-1:0] bullets,
                                input logic signed [DELAY_W-1:0] delay, input logic spare);
        logic [CFG_DATA_W-1:0] word;
        word    = CFG_DATA_W'($urandom);
        word[0] = af;
        write_reg(REG_AUTOFIRE, word);
        word                  = CFG_DATA_W'($urandom);
        word[BULLETS_W-1:0]   = bullets;
        write_reg(REG_BULLETS, word);
        write_reg(REG_DELAY, delay);
        if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // ticks, mostly on consecutive frames so scheduled shots come due, and other items
    task automatic random_item();
        int                pick;
        int                step;
        logic [CMD_W-1:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            step = $urandom_range(0, 9);
            if (step < 8) frame_now = frame_now + 1'b1;
            else if (step == 9) frame_now = $urandom;
            code = CMD_TICK;
        end else if (pick < 62) begin
            code = CMD_FIRE_PRESS;
        end else if (pick < 67) begin
            code = CMD_FIRE_RELEASE;
        end else if (pick < 95) begin
            code = CMD_W'($urandom_range(int'(CMD_UP), int'(CMD_RELEASE_BOTH)));
        end else begin
            code = CMD_W'($urandom_range(int'(CMD_UNDEF_LO), int'(CMD_UNDEF_HI)));
        end
        send_item(code, frame_now);
    endtask

    // random settings, extremes included, then a burst of items
    task automatic random_phase();
        logic                        af;
        logic signed [BULLETS_W-1:0] bullets;
        logic signed [DELAY_W-1:0]   delay;
        int                          burst;
        drain();
        af = ($urandom_range(0, 99) < 80);
        case ($urandom_range(0, 7))
            0:       bullets = -9'sd128;
            1:       bullets = -9'sd1;
            2:       bullets = 9'sd0;
            3:       bullets = 9'sd255;
            default: bullets = BULLETS_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
            0:       delay = -17'sd1;
            1:       delay = 17'sd65535;
            2:       delay = 17'sd0;
            3:       delay = DELAY_W'($urandom_range(0, 65535));
            default: delay = DELAY_W'($urandom_range(1, 4));
        endcase
        program_regs(af, bullets, delay, $urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0:       frame_now = 32'hFFFF_FFF8;
            1:       frame_now = $urandom;
            default: ;
        endcase
        burst = $urandom_range(8, 40);
        repeat (burst) random_item();
    endtask

    initial begin
        int directed_items;
        i_rst_n             = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = CMD_UP;
        cmd_ch.frame_number = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_AUTOFIRE;
        cfg_ch.data         = '0;
        res_ch.ready        = 1'b0;
        frame_now           = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain stick and fire moves with autofire off, frame extremes, undefined code
        send_item(CMD_UP, '0);
        send_item(CMD_DOWN, '1);
        send_item(CMD_LEFT, 32'h5555_5555);
        send_item(CMD_RIGHT, 32'hAAAA_AAAA);
        send_item(CMD_RELEASE_X, '0);
        send_item(CMD_RELEASE_Y, '0);
        send_item(CMD_LEFT, '0);
        send_item(CMD_RELEASE_BOTH, '0);
        send_item(CMD_FIRE_PRESS, 32'd125);
        send_item(CMD_TICK, 32'd125);
        send_item(CMD_FIRE_RELEASE, 32'd126);
        send_item(CMD_UNDEF_HI, 32'd126);

        // two-shot burst across the frame wrap, release ignored
        drain();
        program_regs(1'b1, 9'sd2, 17'sd1, 1'b1);
        send_item(CMD_FIRE_PRESS, 32'hFFFF_FFFE);
        send_item(CMD_TICK, 32'hFFFF_FFFF);
        send_item(CMD_FIRE_RELEASE, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 32'd0);
        send_item(CMD_TICK, 32'd1);
        send_item(CMD_TICK, 32'd2);

        // empty magazine still presses, ticks do nothing
        drain();
        program_regs(1'b1, 9'sd0, 17'sd65535, 1'b0);
        send_item(CMD_FIRE_PRESS, 32'd5);
        send_item(CMD_TICK, 32'd65540);

        // unlimited magazine at the longest delay, then cease fire
        drain();
        program_regs(1'b1, -9'sd128, 17'sd65535, 1'b0);
        send_item(CMD_FIRE_PRESS, 32'd10);
        send_item(CMD_TICK, 32'd65545);
        send_item(CMD_FIRE_PRESS, 32'd65545);

        // negative delay holds the button
        drain();
        program_regs(1'b1, 9'sd255, -17'sd1, 1'b0);
        send_item(CMD_FIRE_PRESS, 32'd100);
        send_item(CMD_TICK, 32'd99);

        // new count while loaded reloads, delay back to positive
        drain();
        program_regs(1'b1, 9'sd3, 17'sd2, 1'b0);
        send_item(CMD_TICK, 32'd99);

        // autofire off again, with the button already released by the last tick
        drain();
        program_regs(1'b0, 9'sd3, 17'sd2, 1'b0);
        frame_now      = 32'd200;
        directed_items = items_sent;

        while (items_sent < directed_items + ITEM_TARGET) random_phase();

        drain();
        repeat (3) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
